// ----- hdl/ibm_ieee_float_converter_core_assert.svh -----
// Assertion macro used by the checker file.
`ifndef IBM_IEEE_FLOAT_CONVERTER_CORE_ASSERT_SVH
`define IBM_IEEE_FLOAT_CONVERTER_CORE_ASSERT_SVH

// Property that must hold at every rising clock edge outside reset.
`define IIFC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ----- hdl/iifc_pkg.sv -----
package iifc_pkg;

  localparam logic DirIbmToIeee = 1'b0;
  localparam logic DirIeeeToIbm = 1'b1;

  typedef struct packed {
    logic [31:0] word;
    logic        ovf;
    logic        unf;
  } conv_res_t;

  // Position of the highest set bit of a 24-bit value (0 when zero).
  function automatic logic [4:0] lead_one24(input logic [23:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

endpackage

// ----- hdl/iifc_ibm2ieee.sv -----
module iifc_ibm2ieee
  import iifc_pkg::*;
(
  input  logic [31:0] w_i,
  output conv_res_t   res_o
);

  logic        sign;
  logic [6:0]  e;
  logic [23:0] f;
  logic [4:0]  p;
  logic signed [10:0] biased;
  logic signed [10:0] k;
  logic [5:0]  r;
  logic [47:0] fext;
  logic [47:0] mask;
  logic [47:0] rem;
  logic [47:0] half;
  logic [31:0] q;
  logic [23:0] shl;

  always_comb begin
    sign   = w_i[31];
    e      = w_i[30:24];
    f      = w_i[23:0];
    p      = lead_one24(f);
    biased = 11'(p) + 11'(e) * 11'sd4 - 11'sd153;
    k      = 11'(e) * 11'sd4 - 11'sd131;
    r      = 6'(-k);
    fext   = {24'd0, f};
    mask   = (48'd1 << r) - 48'd1;
    rem    = fext & mask;
    half   = 48'd1 << (r - 6'd1);
    shl    = f << (5'd23 - p);
    q      = 32'd0;
    if (k >= 0) begin
      q = 32'(fext << k[5:0]);
    end else if (k >= -11'sd24) begin
      q = 32'(fext >> r);
      if (rem > half || (rem == half && q[0])) begin
        q = q + 32'd1;
      end
    end
    res_o.ovf  = 1'b0;
    res_o.unf  = 1'b0;
    res_o.word = {sign, 31'd0};
    if (f == 24'd0) begin
      res_o.word = {sign, 31'd0};
    end else if (biased >= 11'sd255) begin
      res_o.word = {sign, 8'hff, 23'd0};
      res_o.ovf  = 1'b1;
    end else if (biased >= 11'sd1) begin
      res_o.word = {sign, biased[7:0], shl[22:0]};
    end else begin
      res_o.word = {sign, q[30:0]};
      res_o.unf  = (q[30:23] == 8'd0);
    end
  end

endmodule

// ----- hdl/iifc_ieee2ibm.sv -----
module iifc_ieee2ibm
  import iifc_pkg::*;
(
  input  logic [31:0] w_i,
  output conv_res_t   res_o
);

  logic        sign;
  logic [7:0]  ex;
  logic [22:0] mant;
  logic [23:0] m;
  logic signed [9:0] e2;
  logic signed [9:0] b;
  logic signed [9:0] x;
  logic signed [9:0] s;
  logic [23:0] frac;
  logic [9:0]  bsum;
  logic [6:0]  xe;

  always_comb begin
    sign = w_i[31];
    ex   = w_i[30:23];
    mant = w_i[22:0];
    if (ex == 8'd0) begin
      m  = {1'b0, mant};
      e2 = -10'sd149;
    end else begin
      m  = {1'b1, mant};
      e2 = 10'(ex) - 10'sd150;
    end
    b    = 10'(lead_one24(m)) + e2;
    bsum = 10'(b + 10'sd152);
    x    = 10'({2'b00, bsum[9:2]}) - 10'sd37;
    s    = e2 - (x <<< 2) + 10'sd24;
    if (s >= 0) begin
      frac = m << s[4:0];
    end else begin
      frac = m >> 5'(-s);
    end
    xe = 7'(x + 10'sd64);
    res_o.ovf  = 1'b0;
    res_o.unf  = 1'b0;
    if (ex == 8'hff) begin
      res_o.word = (mant != 23'd0) ? 32'd0 : {sign, 31'h7fffffff};
      res_o.ovf  = (mant == 23'd0);
    end else if (ex == 8'd0 && mant == 23'd0) begin
      res_o.word = 32'd0;
    end else begin
      res_o.word = {sign, xe, frac};
    end
  end

endmodule

// ----- hdl/ibm_ieee_float_converter_core.sv -----
// Items pass through an input register and then a result register.
// Throughput: one item per cycle while the result is not stalled; conversion is a single combinational pass.
// A new item is accepted while the input register is empty or moves on, so a
// stalled result stops the input only once both registers hold an item.
// Reset: asynchronous, active low; clears valids and sets direction to IBM to IEEE.
module ibm_ieee_float_converter_core
  import iifc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] source_word_i,
  input  logic        block_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] converted_word_o,
  output logic        out_of_range_o,
  output logic        underflowed_o,
  output logic        block_end_out_o
);

  logic        dir_q;
  logic        v1_q;
  logic [31:0] w1_q;
  logic        be1_q;
  logic        v2_q;
  conv_res_t   r2_q;
  logic        be2_q;
  conv_res_t   ra, rb, rsel;
  logic        adv2, adv1;

  iifc_ibm2ieee u_i2e (.w_i(w1_q), .res_o(ra));
  iifc_ieee2ibm u_e2i (.w_i(w1_q), .res_o(rb));

  assign rsel       = (dir_q == DirIeeeToIbm) ? rb : ra;
  assign adv2       = !v2_q || !out_stall_i;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirIbmToIeee;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      w1_q  <= source_word_i;
      be1_q <= block_end_i;
    end
    if (adv2 && v1_q) begin
      r2_q  <= rsel;
      be2_q <= be1_q;
    end
  end

  assign out_valid_o      = v2_q;
  assign converted_word_o = r2_q.word;
  assign out_of_range_o   = r2_q.ovf;
  assign underflowed_o    = r2_q.unf;
  assign block_end_out_o  = be2_q;

endmodule

// ----- hdl/iifc_checker.sv -----
`include "ibm_ieee_float_converter_core_assert.svh"
module iifc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] converted_word_o,
  input logic        out_of_range_o,
  input logic        underflowed_o
);

  `IIFC_ASSERT(a_out_hold, clk_i, rst_ni,
      (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(converted_word_o)),
      "stalled result changed")
  `IIFC_ASSERT(a_flags_excl, clk_i, rst_ni,
      out_valid_o |-> !(out_of_range_o && underflowed_o),
      "both flags set")
  `IIFC_ASSERT(a_in_free, clk_i, rst_ni,
      !out_valid_o |-> !in_stall_o,
      "input stalled with empty output")
  `IIFC_ASSERT(a_ovf_word, clk_i, rst_ni,
      (out_valid_o && out_of_range_o) |-> (converted_word_o[30:23] == 8'hff),
      "out-of-range word is not saturated")

endmodule

bind ibm_ieee_float_converter_core iifc_checker u_iifc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .converted_word_o(converted_word_o), .out_of_range_o(out_of_range_o),
  .underflowed_o(underflowed_o));
